/* rtl/bos_pkg.sv */
package bos_pkg;

	// hang test: hang > len / HANG_DIV, evaluated as HANG_DIV * hang > len
	localparam int unsigned HANG_DIV = 20;
	localparam int unsigned HANG_DIV_BITS = 5;

	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	// per-edge classification produced by the front end
	typedef struct packed {
		logic is_left;  // a_hang_minus > a_hang_plus
		logic a_left;   // left edge passing the a-side hang test
		logic a_right;  // strict right edge passing the a-side hang test
		logic r_open;   // a_hang_plus test alone (right side when opening a group)
		logic b_ok;     // b-side hang test
		logic eos;      // final edge of the stream
	} cls_t;

	typedef enum logic [1:0] {
		PH_HEAD = 2'b01,
		PH_EOS  = 2'b10
	} phase_t;

endpackage

/* rtl/best_overlap_selector.sv */
// Best overlap selector. Takes overlap edges sorted by read_a; consecutive
// edges with the same read_a form a group. Each edge is classed left
// (a_hang_minus > a_hang_plus) or right, must beat the a-side hang test
// (hang > a_len / 20), and, past the first edge of a group, the b-side test.
// Per group the longest left and longest right edge are held; on a group
// change they are sent out left first, then right, each only if its held
// overlap length is nonzero. end_of_stream flushes the group after the edge
// and closes it. last_of_run marks the final beat caused by one input edge.
// Rate: an edge that stays in the current group is taken by the back end
// without waiting on the output, so such edges stream at one per cycle
// while no flush is pending. Every result beat passes the back end's
// single output register: a group change adds a beat per held edge
// flushed ahead of the edge, and end_of_stream one per edge flushed after
// it (at most three result beats for one edge). A beat passes the front
// register, the queue and the output register when the edge flushes a
// closing group; an end_of_stream flush comes later, since the back end
// takes the edge before it flushes. The front end classifies edges and the
// back end selects; a short queue between them lets either side stall alone.
module best_overlap_selector
	import bos_pkg::*;
#(
	parameter int ID_BITS     = 24,
	parameter int LEN_BITS    = 20,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ID_BITS-1:0]  read_a,
	input  logic [ID_BITS-1:0]  read_b,
	input  logic [LEN_BITS-1:0] a_hang_minus,
	input  logic [LEN_BITS-1:0] a_hang_plus,
	input  logic [LEN_BITS-1:0] b_hang_minus,
	input  logic [LEN_BITS-1:0] b_hang_plus,
	input  logic [LEN_BITS-1:0] a_len,
	input  logic [LEN_BITS-1:0] b_len,
	input  logic [LEN_BITS-1:0] overlap_len,
	input  logic                end_of_stream,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [ID_BITS-1:0]  out_read_a,
	output logic [ID_BITS-1:0]  out_read_b,
	output logic [LEN_BITS-1:0] out_a_hang_minus,
	output logic [LEN_BITS-1:0] out_a_hang_plus,
	output logic [LEN_BITS-1:0] out_b_hang_minus,
	output logic [LEN_BITS-1:0] out_b_hang_plus,
	output logic [LEN_BITS-1:0] out_a_len,
	output logic [LEN_BITS-1:0] out_b_len,
	output logic [LEN_BITS-1:0] out_overlap_len,
	output logic                side,
	output logic                last_of_run
);

	localparam int EW  = 2*ID_BITS + 7*LEN_BITS;
	localparam int CW  = $bits(cls_t);
	localparam int QLW = $clog2(QUEUE_DEPTH+1);

	// edge word, overlap_len in the low bits, read_a on top
	logic [EW-1:0]    in_edge, q_edge, head_edge, res_edge;
	cls_t             q_cls, head_cls;
	logic             q_push, q_ready, head_valid, pop;
	logic [EW+CW-1:0] head_data;
	logic [QLW-1:0]   q_level;

	assign in_edge = {read_a, read_b, a_hang_minus, a_hang_plus, b_hang_minus,
	                  b_hang_plus, a_len, b_len, overlap_len};

	bos_front #(
		.ID_BITS  (ID_BITS),
		.LEN_BITS (LEN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_edge  (in_edge),
		.in_eos   (end_of_stream),
		.q_push   (q_push),
		.q_ready  (q_ready),
		.q_edge   (q_edge),
		.q_cls    (q_cls)
	);

	// classified edges waiting for the back end
	bos_fifo #(
		.WIDTH (EW + CW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_data  ({q_cls, q_edge}),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data),
		.level      (q_level)
	);

	assign head_edge = head_data[EW-1:0];
	assign head_cls  = cls_t'(head_data[EW+CW-1:EW]);

	bos_back #(
		.ID_BITS  (ID_BITS),
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_edge  (head_edge),
		.head_cls   (head_cls),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_edge   (res_edge),
		.out_side   (side),
		.out_last   (last_of_run)
	);

	assign {out_read_a, out_read_b, out_a_hang_minus, out_a_hang_plus, out_b_hang_minus,
	        out_b_hang_plus, out_a_len, out_b_len, out_overlap_len} = res_edge;

	// a beat that is not the last of its run is followed by the next one;
	// the back end never waits on the queue mid-run
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |-> ##2 (out_valid || $past(out_valid)))
		else $error("result run broken before its last beat");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QLW'(QUEUE_DEPTH))
		else $error("edge queue overfilled");

	// input back-pressure only comes from a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (q_level == QLW'(QUEUE_DEPTH)))
		else $error("input stalled with room in the queue");

endmodule

/* rtl/bos_front.sv */
module bos_front
	import bos_pkg::*;
#(
	parameter int ID_BITS  = 24,
	parameter int LEN_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2*ID_BITS+7*LEN_BITS-1:0] in_edge,
	input  logic                          in_eos,
	output logic                          q_push,
	input  logic                          q_ready,
	output logic [2*ID_BITS+7*LEN_BITS-1:0] q_edge,
	output cls_t                          q_cls
);

	localparam int EW = 2*ID_BITS + 7*LEN_BITS;
	localparam int MW = LEN_BITS + int'(HANG_DIV_BITS);

	logic [LEN_BITS-1:0] ahm, ahp, bhm, bhp, al, bl;
	logic [MW-1:0]       ahm20, ahp20, bhm20, bhp20;
	cls_t                cls;

	logic                valid_s1;
	logic [EW-1:0]       edge_s1;
	cls_t                cls_s1;

	assign bl  = in_edge[1*LEN_BITS +: LEN_BITS];
	assign al  = in_edge[2*LEN_BITS +: LEN_BITS];
	assign bhp = in_edge[3*LEN_BITS +: LEN_BITS];
	assign bhm = in_edge[4*LEN_BITS +: LEN_BITS];
	assign ahp = in_edge[5*LEN_BITS +: LEN_BITS];
	assign ahm = in_edge[6*LEN_BITS +: LEN_BITS];

	// constant multiply: two shifted adds
	assign ahm20 = MW'(ahm) * MW'(HANG_DIV);
	assign ahp20 = MW'(ahp) * MW'(HANG_DIV);
	assign bhm20 = MW'(bhm) * MW'(HANG_DIV);
	assign bhp20 = MW'(bhp) * MW'(HANG_DIV);

	always_comb begin
		cls.is_left = ahm > ahp;
		cls.a_left  = (ahm > ahp) && (ahm20 > MW'(al));
		cls.a_right = (ahm < ahp) && (ahp20 > MW'(al));
		cls.r_open  = ahp20 > MW'(al);
		cls.b_ok    = ((bhm > bhp) && (bhm20 > MW'(bl))) ||
		              ((bhm < bhp) && (bhp20 > MW'(bl)));
		cls.eos     = in_eos;
	end

	assign in_ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			edge_s1 <= in_edge;
			cls_s1  <= cls;
		end
	end

	assign q_push = valid_s1;
	assign q_edge = edge_s1;
	assign q_cls  = cls_s1;

endmodule

/* rtl/bos_fifo.sv */
module bos_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         push_ready,
	input  logic [WIDTH-1:0]             push_data,
	output logic                         head_valid,
	input  logic                         pop,
	output logic [WIDTH-1:0]             head_data,
	output logic [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [LW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != LW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign level      = cnt_q;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/bos_back.sv */
module bos_back
	import bos_pkg::*;
#(
	parameter int ID_BITS  = 24,
	parameter int LEN_BITS = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  logic [2*ID_BITS+7*LEN_BITS-1:0] head_edge,
	input  cls_t                            head_cls,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2*ID_BITS+7*LEN_BITS-1:0] out_edge,
	output logic                            out_side,
	output logic                            out_last
);

	localparam int EW = 2*ID_BITS + 7*LEN_BITS;

	phase_t              ph_q, ph_d;
	logic                grp_valid_q;
	logic [ID_BITS-1:0]  grp_read_q;
	logic [LEN_BITS-1:0] lbl_q, rbl_q, lbl_d, rbl_d;
	logic [EW-1:0]       lrec_q, rrec_q;

	logic                out_valid_q, out_side_q, out_last_q;
	logic [EW-1:0]       out_edge_q;

	logic [ID_BITS-1:0]  ra;
	logic [LEN_BITS-1:0] ol;
	logic                new_grp, slot_free, old_l, old_r, eos_any;
	logic [LEN_BITS-1:0] upd_lbl, upd_rbl;
	logic                wr_l, wr_r, do_wr_l, do_wr_r;
	logic                set_grp, clr_grp;
	logic                load, ld_side, ld_last;
	logic [EW-1:0]       ld_edge;

	assign ra        = head_edge[EW-1 -: ID_BITS];
	assign ol        = head_edge[LEN_BITS-1:0];
	assign new_grp   = !grp_valid_q || (ra != grp_read_q);
	assign slot_free = !out_valid_q || out_ready;
	assign old_l     = new_grp && (lbl_q != '0);
	assign old_r     = new_grp && (rbl_q != '0);

	// state after taking the head edge
	always_comb begin
		upd_lbl = lbl_q;
		upd_rbl = rbl_q;
		wr_l    = 1'b0;
		wr_r    = 1'b0;
		if (new_grp) begin
			if (head_cls.is_left) begin
				wr_l    = head_cls.a_left;
				upd_lbl = head_cls.a_left ? ol : '0;
				upd_rbl = '0;
			end else begin
				wr_r    = head_cls.r_open;
				upd_rbl = head_cls.r_open ? ol : '0;
				upd_lbl = '0;
			end
		end else if (head_cls.a_left) begin
			if (head_cls.b_ok && (ol > lbl_q)) begin
				wr_l    = 1'b1;
				upd_lbl = ol;
			end
		end else if (head_cls.a_right) begin
			if (head_cls.b_ok && (ol > rbl_q)) begin
				wr_r    = 1'b1;
				upd_rbl = ol;
			end
		end
		eos_any = head_cls.eos && ((upd_lbl != '0) || (upd_rbl != '0));
	end

	always_comb begin
		ph_d    = ph_q;
		lbl_d   = lbl_q;
		rbl_d   = rbl_q;
		pop     = 1'b0;
		do_wr_l = 1'b0;
		do_wr_r = 1'b0;
		set_grp = 1'b0;
		clr_grp = 1'b0;
		load    = 1'b0;
		ld_edge = lrec_q;
		ld_side = SIDE_LEFT;
		ld_last = 1'b0;
		unique case (ph_q)
			PH_HEAD: begin
				if (head_valid) begin
					// flush the closing group one edge a cycle while the output slot is free, then take the edge
					if (old_l) begin
						if (slot_free) begin
							load    = 1'b1;
							ld_last = !(old_r || eos_any);
							lbl_d   = '0;
						end
					end else if (old_r) begin
						if (slot_free) begin
							load    = 1'b1;
							ld_edge = rrec_q;
							ld_side = SIDE_RIGHT;
							ld_last = !eos_any;
							rbl_d   = '0;
						end
					end else begin
						pop     = 1'b1;
						lbl_d   = upd_lbl;
						rbl_d   = upd_rbl;
						do_wr_l = wr_l;
						do_wr_r = wr_r;
						set_grp = new_grp;
						if (head_cls.eos) begin
							if (eos_any) begin
								ph_d = PH_EOS;
							end else begin
								clr_grp = 1'b1;
							end
						end
					end
				end
			end
			PH_EOS: begin
				if (slot_free) begin
					load = 1'b1;
					if (lbl_q != '0) begin
						ld_last = rbl_q == '0;
						lbl_d   = '0;
					end else begin
						ld_edge = rrec_q;
						ld_side = SIDE_RIGHT;
						ld_last = 1'b1;
						rbl_d   = '0;
					end
					if (ld_last) begin
						clr_grp = 1'b1;
						ph_d    = PH_HEAD;
					end
				end
			end
			default: begin
				ph_d = PH_HEAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_HEAD;
			grp_valid_q <= 1'b0;
			grp_read_q  <= '0;
			lbl_q       <= '0;
			rbl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			if (clr_grp) begin
				grp_valid_q <= 1'b0;
				grp_read_q  <= '0;
				lbl_q       <= '0;
				rbl_q       <= '0;
			end else begin
				if (set_grp) begin
					grp_valid_q <= 1'b1;
					grp_read_q  <= ra;
				end
				lbl_q <= lbl_d;
				rbl_q <= rbl_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr_l) begin
			lrec_q <= head_edge;
		end
		if (do_wr_r) begin
			rrec_q <= head_edge;
		end
		if (load) begin
			out_edge_q <= ld_edge;
			out_side_q <= ld_side;
			out_last_q <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_edge  = out_edge_q;
	assign out_side  = out_side_q;
	assign out_last  = out_last_q;

endmodule
